// ===== rtl/ukst_pkg.sv =====
// Shared constants, codes and control types for the unique key set table.
// Used by the controller, the datapath, the top level and the checker.
package ukst_pkg;

	localparam int CAPACITY  = 16;
	localparam int KEY_WIDTH = 32;
	localparam int POS_W     = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int IN_DATA_W = ((KEY_WIDTH + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((POS_W + CNT_W + 7) / 8) * 8;

	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic capture;
		logic update;
	} ukst_cmd_t;

	typedef struct packed {
		logic out_busy;
	} ukst_stat_t;

endpackage

// ===== rtl/unique_key_set_table.sv =====
// Top level of the unique key set table: stream ports around the controller
// and datapath. Depends on ukst_pkg, ukst_ctrl and ukst_dp.
//
// Holds up to 16 distinct 32-bit keys in insertion order. Each input transfer
// carries a command (add, remove, search) and a key; each yields exactly one
// result transfer with status, position and the key count after the command.
// The key of a command is compared against every held entry in the cycle it
// is accepted, and the table is appended to or shifted down in the update state
// that follows. The update cycle waits while the previous result has not been
// taken, so a stalled output holds off the next command by the stall time.
// The table is empty after reset; no clearing pass is needed.
module unique_key_set_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [ukst_pkg::IN_DATA_W-1:0]    s_tdata,  // key
	input  logic [ukst_pkg::CMD_W-1:0]        s_tuser,  // cmd
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ukst_pkg::OUT_DATA_W-1:0]   m_tdata,  // position, count, zero pad
	output logic [ukst_pkg::STATUS_W-1:0]     m_tuser   // status
);
	import ukst_pkg::*;

	ukst_cmd_t         cmd;
	ukst_stat_t        stat;
	logic [POS_W-1:0]  position;
	logic [CNT_W-1:0]  count;

	ukst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ukst_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_cmd       (s_tuser),
		.in_key       (s_tdata[KEY_WIDTH-1:0]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_status   (m_tuser),
		.out_position (position),
		.out_count    (count)
	);

	assign m_tdata = OUT_DATA_W'({count, position});

endmodule

// ===== rtl/ukst_ctrl.sv =====
// Controller for the unique key set table: two-state sequencer that takes a
// command, then lets the datapath update the table. Depends on ukst_pkg.
module ukst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ukst_pkg::ukst_stat_t stat,
	output ukst_pkg::ukst_cmd_t  cmd
);
	import ukst_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_UPD  = 1'b1;

	logic state_q;
	logic state_d;

	assign in_ready    = (state_q == S_IDLE);
	assign cmd.capture = in_valid && in_ready;
	assign cmd.update  = (state_q == S_UPD) && !stat.out_busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.capture) state_d = S_UPD;
			end
			S_UPD: begin
				if (cmd.update) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/ukst_dp.sv =====
// Datapath for the unique key set table: key store, parallel compare,
// append / shift-down update and the result register. Depends on ukst_pkg.
module ukst_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ukst_pkg::ukst_cmd_t           cmd,
	output ukst_pkg::ukst_stat_t          stat,
	input  logic [ukst_pkg::CMD_W-1:0]    in_cmd,
	input  logic [ukst_pkg::KEY_WIDTH-1:0] in_key,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ukst_pkg::STATUS_W-1:0] out_status,
	output logic [ukst_pkg::POS_W-1:0]    out_position,
	output logic [ukst_pkg::CNT_W-1:0]    out_count
);
	import ukst_pkg::*;

	logic [KEY_WIDTH-1:0] entries_q [CAPACITY];
	logic [CNT_W-1:0]     count_q;

	logic [CMD_W-1:0]     cmd_s1;
	logic [KEY_WIDTH-1:0] key_s1;
	logic                 hit_s1;
	logic [POS_W-1:0]     idx_s1;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [POS_W-1:0]     pos_q;

	logic [CAPACITY-1:0]  match;
	logic                 hit;
	logic [POS_W-1:0]     idx;

	logic [STATUS_W-1:0]  status_d;
	logic [POS_W-1:0]     pos_d;
	logic [CNT_W-1:0]     count_d;
	logic                 do_append;
	logic                 do_shift;

	// compare against occupied entries, lowest matching index wins
	always_comb begin
		hit = 1'b0;
		idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			match[i] = (CNT_W'(i) < count_q) && (entries_q[i] == in_key);
		end
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit = 1'b1;
				idx = POS_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_s1 <= in_cmd;
			key_s1 <= in_key;
			hit_s1 <= hit;
			idx_s1 <= idx;
		end
	end

	always_comb begin
		status_d  = ST_OK;
		pos_d     = '0;
		count_d   = count_q;
		do_append = 1'b0;
		do_shift  = 1'b0;
		case (cmd_s1)
			CMD_ADD: begin
				if (hit_s1) begin
					status_d = ST_DUP;
				end else if (count_q >= CNT_W'(CAPACITY)) begin
					status_d = ST_FULL;
				end else begin
					do_append = 1'b1;
					count_d   = count_q + 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (!hit_s1) begin
					status_d = ST_MISSING;
				end else begin
					do_shift = 1'b1;
					count_d  = count_q - 1'b1;
					pos_d    = idx_s1;
				end
			end
			CMD_SEARCH: begin
				if (!hit_s1) begin
					status_d = ST_MISSING;
				end else begin
					pos_d = idx_s1;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			if (do_append) begin
				entries_q[count_q[POS_W-1:0]] <= key_s1;
			end
			if (do_shift) begin
				for (int i = 0; i < CAPACITY - 1; i++) begin
					if (POS_W'(i) >= idx_s1) entries_q[i] <= entries_q[i+1];
				end
			end
			status_q <= status_d;
			pos_q    <= pos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign out_status    = status_q;
	assign out_position  = pos_q;
	assign out_count     = count_q;

endmodule

// ===== rtl/ukst_chk.sv =====
// Port-level checker for the unique key set table, bound to the top level.
// Depends on ukst_pkg.
module ukst_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [ukst_pkg::OUT_DATA_W-1:0]   m_tdata,
	input logic [ukst_pkg::STATUS_W-1:0]     m_tuser
);
	import ukst_pkg::*;

	logic [POS_W-1:0] pos;
	logic [CNT_W-1:0] cnt;

	assign pos = m_tdata[POS_W-1:0];
	assign cnt = m_tdata[POS_W+CNT_W-1:POS_W];

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a command is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_FULL |-> cnt == CNT_W'(CAPACITY))
		else $error("full status with room left");

	a_fail_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_DUP || m_tuser == ST_MISSING) |-> pos == '0)
		else $error("nonzero position on refused command");

endmodule

bind unique_key_set_table ukst_chk u_ukst_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
